/* hw/rtl/pwts_pkg.sv */
// ----------------------------------------------------------------------------
// pwts_pkg
// shared types and codes for the world-to-screen projection block
// ----------------------------------------------------------------------------
package pwts_pkg;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BEHIND = 2'd1,
        ST_SMALL  = 2'd2,
        ST_OVF    = 2'd3
    } t_status;

    localparam int NUM_REGS = 8;
    localparam int IDX_W    = 4;
    localparam int CFG_W    = 64;

    localparam logic [IDX_W-1:0] REG_ROW0_AB = 4'd0;
    localparam logic [IDX_W-1:0] REG_ROW0_CD = 4'd1;
    localparam logic [IDX_W-1:0] REG_ROW1_AB = 4'd2;
    localparam logic [IDX_W-1:0] REG_ROW1_CD = 4'd3;
    localparam logic [IDX_W-1:0] REG_ROW3_AB = 4'd4;
    localparam logic [IDX_W-1:0] REG_ROW3_CD = 4'd5;
    localparam logic [IDX_W-1:0] REG_WIDTH   = 4'd6;
    localparam logic [IDX_W-1:0] REG_HEIGHT  = 4'd7;

    // divider remainder width: denominator is 2*w with w < 2^31
    localparam int DEN_W = 33;

    // data riding alongside the divider chain
    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cw;
        t_status            st;
        logic               ovf;
        logic               sgn_x;
        logic               sgn_y;
    } t_side;

endpackage

/* hw/rtl/pwts_if.sv */
// ----------------------------------------------------------------------------
// pwts channel interfaces
// point input, projected result output and register write channels
// ----------------------------------------------------------------------------
interface pwts_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    modport source (output valid, pos_x, pos_y, pos_z, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface pwts_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] clip_x;
    logic signed [31:0] clip_y;
    logic signed [31:0] clip_w;
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic [1:0]         status;
    modport source (output valid, clip_x, clip_y, clip_w, screen_x, screen_y, status,
                    input ready);
    modport sink   (input valid, clip_x, clip_y, clip_w, screen_x, screen_y, status,
                    output ready);
endinterface

interface pwts_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [pwts_pkg::IDX_W-1:0]      index;
    logic [pwts_pkg::CFG_W-1:0]      data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/pwts_div_cell.sv */
// ----------------------------------------------------------------------------
// pwts_div_cell
// one restoring-division step: retires one quotient bit per cell
// ----------------------------------------------------------------------------
module pwts_div_cell #(
    parameter int NW = 63
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [pwts_pkg::DEN_W-1:0]    i_rem,
    input  logic [NW-1:0]                 i_num,
    input  logic [pwts_pkg::DEN_W-1:0]    i_den,
    output logic [pwts_pkg::DEN_W-1:0]    o_rem,
    output logic [NW-1:0]                 o_num,
    output logic [pwts_pkg::DEN_W-1:0]    o_den
);
    localparam int TW = pwts_pkg::DEN_W + 1;

    logic [pwts_pkg::DEN_W-1:0] r_rem, n_rem;
    logic [NW-1:0]              r_num, n_num;
    logic [pwts_pkg::DEN_W-1:0] r_den;
    logic [TW-1:0]              w_t, w_diff;
    logic                       w_ge;

    always_comb begin
        w_t    = {i_rem, i_num[NW-1]};
        w_diff = w_t - {1'b0, i_den};
        w_ge   = (w_t >= {1'b0, i_den});
        n_rem  = w_ge ? w_diff[pwts_pkg::DEN_W-1:0] : w_t[pwts_pkg::DEN_W-1:0];
        // numerator bits leave at the top, quotient bits enter at the bottom
        n_num  = {i_num[NW-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_num <= n_num;
            r_den <= i_den;
        end
    end

    assign o_rem = r_rem;
    assign o_num = r_num;
    assign o_den = r_den;
endmodule

/* hw/rtl/perspective_world_to_screen.sv */
// ----------------------------------------------------------------------------
// perspective_world_to_screen
// projects a Q.F world point through a 4x4 view-projection matrix to pixels
// ----------------------------------------------------------------------------
// channel  dir  beat contents
// i_pt     in   pos_x, pos_y, pos_z
// o_res    out  clip_x, clip_y, clip_w, screen_x, screen_y, status
// i_cfg    in   index, data (register write, always ready)
//
// one beat per cycle while o_res is not stalled; the pipeline is the chain of
// divider cells (one quotient bit per cell, 47 + FRAC_BITS cells)
// plus three stages before and two after it.
// reset clears the pipeline valid bits and all configuration registers to zero.
// when o_res is stalled with a result present the whole pipeline holds.
// ----------------------------------------------------------------------------
module perspective_world_to_screen #(
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    pwts_in_if.sink             i_pt,
    pwts_out_if.source          o_res,
    pwts_cfg_if.sink            i_cfg
);
    localparam int F     = FRAC_BITS;
    localparam int DW    = 67;
    localparam int EW    = DW - F;
    localparam int MW    = 47;
    localparam int NW    = MW + F;
    localparam int QW    = NW + 1;
    localparam int SW    = QW + 1;
    localparam int L     = NW + 5;
    localparam int DV    = pwts_pkg::DEN_W;
    localparam longint THR = (64'sd1 <<< F) / 1000;
    localparam logic signed [EW-1:0] W_THR = EW'(THR);
    localparam logic signed [QW-1:0] Q_HI  = QW'(64'd8589934593) <<< F;
    localparam logic signed [QW-1:0] Q_LO  = -(QW'(64'd8589934592) <<< F);
    localparam logic signed [SW-1:0] S_MAX = SW'(64'sd2147483647);
    localparam logic signed [SW-1:0] S_MIN = -SW'(64'sd2147483648);

    logic signed [31:0] r_c [0:2][0:3];
    logic [15:0]        r_width, r_height;
    logic [L-1:0]       r_vld;
    logic               w_en;

    assign w_en        = !r_vld[L-1] || o_res.ready;
    assign i_pt.ready  = w_en;
    assign i_cfg.ready = 1'b1;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                for (int k = 0; k < 4; k++) begin
                    r_c[r][k] <= '0;
                end
            end
            r_width  <= '0;
            r_height <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                pwts_pkg::REG_ROW0_AB: begin
                    r_c[0][0] <= i_cfg.data[31:0]; r_c[0][1] <= i_cfg.data[63:32];
                end
                pwts_pkg::REG_ROW0_CD: begin
                    r_c[0][2] <= i_cfg.data[31:0]; r_c[0][3] <= i_cfg.data[63:32];
                end
                pwts_pkg::REG_ROW1_AB: begin
                    r_c[1][0] <= i_cfg.data[31:0]; r_c[1][1] <= i_cfg.data[63:32];
                end
                pwts_pkg::REG_ROW1_CD: begin
                    r_c[1][2] <= i_cfg.data[31:0]; r_c[1][3] <= i_cfg.data[63:32];
                end
                pwts_pkg::REG_ROW3_AB: begin
                    r_c[2][0] <= i_cfg.data[31:0]; r_c[2][1] <= i_cfg.data[63:32];
                end
                pwts_pkg::REG_ROW3_CD: begin
                    r_c[2][2] <= i_cfg.data[31:0]; r_c[2][3] <= i_cfg.data[63:32];
                end
                pwts_pkg::REG_WIDTH:  r_width  <= i_cfg.data[15:0];
                pwts_pkg::REG_HEIGHT: r_height <= i_cfg.data[15:0];
                default: ;
            endcase
        end
    end

    // ---------------- valid line ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[L-2:0], i_pt.valid};
        end
    end

    // ---------------- stage 1: products ----------------
    logic signed [63:0] r_prod [0:2][0:2];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int r = 0; r < 3; r++) begin
                r_prod[r][0] <= 64'(r_c[r][0] * 64'(i_pt.pos_x));
                r_prod[r][1] <= 64'(r_c[r][1] * 64'(i_pt.pos_y));
                r_prod[r][2] <= 64'(r_c[r][2] * 64'(i_pt.pos_z));
            end
        end
    end

    // ---------------- stage 2: exact dot, rounded half up ----------------
    logic signed [EW-1:0] r_e [0:2];
    logic signed [DW-1:0] w_sum [0:2];
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            w_sum[r] = DW'(r_prod[r][0]) + DW'(r_prod[r][1]) + DW'(r_prod[r][2])
                     + (DW'(r_c[r][3]) <<< F) + (DW'(1) <<< (F - 1));
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int r = 0; r < 3; r++) begin
                r_e[r] <= w_sum[r][DW-1:F];
            end
        end
    end

    // ---------------- stage 3: saturate, status, numerators ----------------
    logic signed [31:0]   w_cl [0:2];
    logic                 w_ovf;
    logic signed [48:0]   w_nx, w_ny, w_ax, w_ay;
    pwts_pkg::t_side      w_side;
    logic [DV-1:0]        r_rem0;
    logic [NW-1:0]        r_numx, r_numy;
    logic [DV-1:0]        r_den;
    pwts_pkg::t_side      r_side3;

    always_comb begin
        w_ovf = 1'b0;
        for (int r = 0; r < 3; r++) begin
            if (&r_e[r][EW-1:31] || ~|r_e[r][EW-1:31]) begin
                w_cl[r] = r_e[r][31:0];
            end else begin
                w_ovf   = 1'b1;
                w_cl[r] = r_e[r][EW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
            end
        end
        w_nx = 49'(w_cl[0] * $signed({1'b0, r_width}));
        w_ny = 49'(w_cl[1] * $signed({1'b0, r_height}));
        w_ax = w_nx[48] ? -w_nx : w_nx;
        w_ay = w_ny[48] ? -w_ny : w_ny;
        w_side.cx    = w_cl[0];
        w_side.cy    = w_cl[1];
        w_side.cw    = w_cl[2];
        w_side.ovf   = w_ovf;
        w_side.sgn_x = w_nx[48];
        w_side.sgn_y = w_ny[48];
        if (r_e[2] <= W_THR) begin
            w_side.st = pwts_pkg::ST_BEHIND;
        end else if (r_width <= 16'd1 || r_height <= 16'd1) begin
            w_side.st = pwts_pkg::ST_SMALL;
        end else begin
            w_side.st = pwts_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rem0  <= '0;
            r_numx  <= {w_ax[MW-1:0], {F{1'b0}}};
            r_numy  <= {w_ay[MW-1:0], {F{1'b0}}};
            r_den   <= {w_cl[2], 1'b0};
            r_side3 <= w_side;
        end
    end

    // ---------------- divider cell chains ----------------
    logic [DV-1:0] w_remx [0:NW];
    logic [DV-1:0] w_remy [0:NW];
    logic [NW-1:0] w_numx [0:NW];
    logic [NW-1:0] w_numy [0:NW];
    logic [DV-1:0] w_denx [0:NW];
    logic [DV-1:0] w_deny [0:NW];

    assign w_remx[0] = r_rem0;
    assign w_remy[0] = r_rem0;
    assign w_numx[0] = r_numx;
    assign w_numy[0] = r_numy;
    assign w_denx[0] = r_den;
    assign w_deny[0] = r_den;

    for (genvar k = 0; k < NW; k++) begin : g_cell
        pwts_div_cell #(.NW(NW)) u_cx (
            .i_clk (i_clk), .i_en (w_en),
            .i_rem (w_remx[k]), .i_num (w_numx[k]), .i_den (w_denx[k]),
            .o_rem (w_remx[k+1]), .o_num (w_numx[k+1]), .o_den (w_denx[k+1])
        );
        pwts_div_cell #(.NW(NW)) u_cy (
            .i_clk (i_clk), .i_en (w_en),
            .i_rem (w_remy[k]), .i_num (w_numy[k]), .i_den (w_deny[k]),
            .o_rem (w_remy[k+1]), .o_num (w_numy[k+1]), .o_den (w_deny[k+1])
        );
    end

    pwts_pkg::t_side r_side [0:NW-1];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0] <= r_side3;
            for (int k = 1; k < NW; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // ---------------- stage 4: signed floored quotient ----------------
    logic signed [QW-1:0] w_px, w_py;
    logic signed [QW-1:0] r_qx, r_qy;
    pwts_pkg::t_side      r_side4;
    always_comb begin
        w_px = {1'b0, w_numx[NW]} + QW'(|w_remx[NW]);
        w_py = {1'b0, w_numy[NW]} + QW'(|w_remy[NW]);
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_qx    <= r_side[NW-1].sgn_x ? -w_px : {1'b0, w_numx[NW]};
            r_qy    <= r_side[NW-1].sgn_y ? -w_py : {1'b0, w_numy[NW]};
            r_side4 <= r_side[NW-1];
        end
    end

    // ---------------- stage 5: clamp, offset, saturate ----------------
    logic signed [QW-1:0] w_tx, w_ty;
    logic                 w_otx, w_oty, w_osx, w_osy;
    logic signed [SW-1:0] w_hw, w_hh, w_sx, w_sy;
    logic signed [31:0]   w_scx, w_scy;
    pwts_pkg::t_status    w_st;

    always_comb begin
        w_otx = (r_qx >= Q_HI) || (r_qx < Q_LO);
        w_oty = (r_qy >= Q_HI) || (r_qy < Q_LO);
        w_tx  = (r_qx >= Q_HI) ? QW'(S_MAX) : (r_qx < Q_LO) ? QW'(S_MIN) : r_qx;
        w_ty  = (r_qy >= Q_HI) ? QW'(S_MAX) : (r_qy < Q_LO) ? QW'(S_MIN) : r_qy;
        w_hw  = SW'({r_width, {(F - 1){1'b0}}});
        w_hh  = SW'({r_height, {(F - 1){1'b0}}});
        w_sx  = w_hw + SW'(w_tx);
        w_sy  = w_hh - SW'(w_ty);
        w_osx = (w_sx > S_MAX) || (w_sx < S_MIN);
        w_osy = (w_sy > S_MAX) || (w_sy < S_MIN);
        w_scx = (w_sx > S_MAX) ? 32'sh7fff_ffff : (w_sx < S_MIN) ? 32'sh8000_0000
              : w_sx[31:0];
        w_scy = (w_sy > S_MAX) ? 32'sh7fff_ffff : (w_sy < S_MIN) ? 32'sh8000_0000
              : w_sy[31:0];
        if (r_side4.st != pwts_pkg::ST_OK) begin
            w_st  = r_side4.st;
            w_scx = '0;
            w_scy = '0;
        end else if (r_side4.ovf || w_otx || w_oty || w_osx || w_osy) begin
            w_st = pwts_pkg::ST_OVF;
        end else begin
            w_st = pwts_pkg::ST_OK;
        end
    end

    logic signed [31:0] r_ocx, r_ocy, r_ocw, r_osx, r_osy;
    pwts_pkg::t_status  r_ost;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ocx <= r_side4.cx;
            r_ocy <= r_side4.cy;
            r_ocw <= r_side4.cw;
            r_osx <= w_scx;
            r_osy <= w_scy;
            r_ost <= w_st;
        end
    end

    assign o_res.valid    = r_vld[L-1];
    assign o_res.clip_x   = r_ocx;
    assign o_res.clip_y   = r_ocy;
    assign o_res.clip_w   = r_ocw;
    assign o_res.screen_x = r_osx;
    assign o_res.screen_y = r_osy;
    assign o_res.status   = r_ost;

    // ---------------- assertions ----------------
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("pipeline moved during stall");

    a_behind_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && r_ost == pwts_pkg::ST_BEHIND |-> r_osx == 0 && r_osy == 0)
        else $error("behind-camera result has nonzero screen position");

    a_ok_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && (r_ost == pwts_pkg::ST_OK || r_ost == pwts_pkg::ST_OVF)
        |-> 64'(r_ocw) > THR)
        else $error("projected result with w at or below threshold");

    a_ok_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && r_ost == pwts_pkg::ST_OK |-> r_width > 16'd1 && r_height > 16'd1)
        else $error("projected result with too small a display");
endmodule

/* tb/pwts_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pwts_checker
// snoops the register writes and point beats, predicts each projected result
// and compares it field by field with the beats leaving the block
// ----------------------------------------------------------------------------
module pwts_checker #(
    parameter int FRAC_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    pwts_in_if   i_pt,
    pwts_out_if  i_res,
    pwts_cfg_if  i_cfg,
    output int   o_pending,
    output int   o_fail_cnt
);

    localparam longint Q_ONE    = longint'(1) << FRAC_BITS;
    localparam longint W_MIN    = Q_ONE / 1000;
    localparam longint S32_MAX  = 64'sd2147483647;
    localparam longint S32_MIN  = -64'sd2147483648;

    typedef struct {
        logic signed [31:0] clip_x;
        logic signed [31:0] clip_y;
        logic signed [31:0] clip_w;
        logic signed [31:0] screen_x;
        logic signed [31:0] screen_y;
        pwts_pkg::t_status  status;
    } t_projection;

    logic [63:0]  row_coef [6];
    logic [15:0]  disp_w;
    logic [15:0]  disp_h;
    t_projection  proj_q [$];

    function automatic longint floor_div(longint n, longint d, output longint rem);
        longint q;
        q   = n / d;
        rem = n % d;
        if (rem < 0) begin
            q   -= 1;
            rem += d;
        end
        return q;
    endfunction

    function automatic longint clamp32(longint v, inout bit ovf);
        if (v > S32_MAX) begin
            ovf = 1'b1;
            return S32_MAX;
        end
        if (v < S32_MIN) begin
            ovf = 1'b1;
            return S32_MIN;
        end
        return v;
    endfunction

    // exact dot of row with (x, y, z, 1), rounded half up to Q.F
    function automatic longint dot_row(int row, longint p [3]);
        longint c [4];
        longint whole;
        longint part;
        longint rem;
        c[0]  = longint'($signed(row_coef[2*row][31:0]));
        c[1]  = longint'($signed(row_coef[2*row][63:32]));
        c[2]  = longint'($signed(row_coef[2*row+1][31:0]));
        c[3]  = longint'($signed(row_coef[2*row+1][63:32]));
        whole = 0;
        part  = Q_ONE / 2;
        for (int i = 0; i < 3; i++) begin
            whole += floor_div(c[i] * p[i], Q_ONE, rem);
            part  += rem;
        end
        whole += c[3];
        whole += floor_div(part, Q_ONE, rem);
        return whole;
    endfunction

    // floor(n * size * 2^F / (2 * w)), w > 0
    function automatic longint scale_by_w(longint n, longint size, longint w, inout bit ovf);
        longint den;
        longint q;
        longint r;
        longint r2;
        longint frac;
        den  = 2 * w;
        q    = floor_div(n * size, den, r);
        frac = floor_div(r * Q_ONE, den, r2);
        if (q > (longint'(1) << 33)) begin
            ovf = 1'b1;
            return S32_MAX;
        end
        if (q < -(longint'(1) << 33)) begin
            ovf = 1'b1;
            return S32_MIN;
        end
        return q * Q_ONE + frac;
    endfunction

    function automatic t_projection project_point(logic signed [31:0] px,
                                                  logic signed [31:0] py,
                                                  logic signed [31:0] pz);
        t_projection res;
        longint p [3];
        longint ex, ey, ew, cx, cy, cw, tx, ty;
        longint w_px, h_px;
        bit     ovf;
        p[0] = px;
        p[1] = py;
        p[2] = pz;
        ovf  = 1'b0;
        w_px = disp_w;
        h_px = disp_h;
        ex   = dot_row(0, p);
        ey   = dot_row(1, p);
        ew   = dot_row(2, p);
        cx   = clamp32(ex, ovf);
        cy   = clamp32(ey, ovf);
        cw   = clamp32(ew, ovf);
        res.screen_x = '0;
        res.screen_y = '0;
        if (ew <= W_MIN) begin
            res.status = pwts_pkg::ST_BEHIND;
        end else if (w_px <= 1 || h_px <= 1) begin
            res.status = pwts_pkg::ST_SMALL;
        end else begin
            tx = scale_by_w(cx, w_px, cw, ovf);
            ty = scale_by_w(cy, h_px, cw, ovf);
            res.screen_x = 32'(clamp32(w_px * (Q_ONE / 2) + tx, ovf));
            res.screen_y = 32'(clamp32(h_px * (Q_ONE / 2) - ty, ovf));
            res.status   = ovf ? pwts_pkg::ST_OVF : pwts_pkg::ST_OK;
        end
        res.clip_x = 32'(cx);
        res.clip_y = 32'(cy);
        res.clip_w = 32'(cw);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_projection want;
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) row_coef[i] <= '0;
            disp_w     <= '0;
            disp_h     <= '0;
            o_fail_cnt <= 0;
            proj_q.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    pwts_pkg::REG_ROW0_AB: row_coef[0] <= i_cfg.data;
                    pwts_pkg::REG_ROW0_CD: row_coef[1] <= i_cfg.data;
                    pwts_pkg::REG_ROW1_AB: row_coef[2] <= i_cfg.data;
                    pwts_pkg::REG_ROW1_CD: row_coef[3] <= i_cfg.data;
                    pwts_pkg::REG_ROW3_AB: row_coef[4] <= i_cfg.data;
                    pwts_pkg::REG_ROW3_CD: row_coef[5] <= i_cfg.data;
                    pwts_pkg::REG_WIDTH:   disp_w      <= i_cfg.data[15:0];
                    pwts_pkg::REG_HEIGHT:  disp_h      <= i_cfg.data[15:0];
                    default: ;
                endcase
            end
            if (i_pt.valid && i_pt.ready)
                proj_q.push_back(project_point(i_pt.pos_x, i_pt.pos_y, i_pt.pos_z));
            if (i_res.valid && i_res.ready) begin
                if (proj_q.size() == 0) begin
                    $error("result beat with no point outstanding");
                    o_fail_cnt <= o_fail_cnt + 1;
                end else begin
                    want = proj_q.pop_front();
                    if (i_res.clip_x !== want.clip_x || i_res.clip_y !== want.clip_y ||
                        i_res.clip_w !== want.clip_w || i_res.screen_x !== want.screen_x ||
                        i_res.screen_y !== want.screen_y || i_res.status !== want.status)
                        o_fail_cnt <= o_fail_cnt + 1;
                    if (i_res.clip_x !== want.clip_x)
                        $error("clip_x expected %0d got %0d", want.clip_x, i_res.clip_x);
                    if (i_res.clip_y !== want.clip_y)
                        $error("clip_y expected %0d got %0d", want.clip_y, i_res.clip_y);
                    if (i_res.clip_w !== want.clip_w)
                        $error("clip_w expected %0d got %0d", want.clip_w, i_res.clip_w);
                    if (i_res.screen_x !== want.screen_x)
                        $error("screen_x expected %0d got %0d", want.screen_x, i_res.screen_x);
                    if (i_res.screen_y !== want.screen_y)
                        $error("screen_y expected %0d got %0d", want.screen_y, i_res.screen_y);
                    if (i_res.status !== want.status)
                        $error("status expected %0d got %0d", want.status, i_res.status);
                end
            end
        end
        o_pending <= proj_q.size();
    end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// world-to-screen projection: directed corner points then random phases,
// each phase loading a new matrix and display size while the block is idle
// ----------------------------------------------------------------------------
module testbench;

    localparam int              FRAC_BITS  = 16;
    localparam int              ONE        = 1 << FRAC_BITS;
    localparam int              S_MAX      = 32'h7fffffff;
    localparam int              S_MIN      = 32'h80000000;
    localparam int              W_EDGE     = ONE / 1000;
    localparam int              DRAIN_CYC  = FRAC_BITS + 60;
    localparam int              HOLD_CYC   = 300;
    localparam logic [pwts_pkg::IDX_W-1:0] IDX_UNUSED = 4'd12;

    logic i_clk;
    logic i_rst_n;
    int   pending;
    int   fail_cnt;
    bit   long_hold_req;
    int   hold_cnt;
    int   run_cnt;

    pwts_in_if  pt_if ();
    pwts_out_if res_if ();
    pwts_cfg_if cfg_if ();

    perspective_world_to_screen #(.FRAC_BITS(FRAC_BITS)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (pt_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    pwts_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pt       (pt_if),
        .i_res      (res_if),
        .i_cfg      (cfg_if),
        .o_pending  (pending),
        .o_fail_cnt (fail_cnt)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    initial begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    function automatic int rand_q(int mag);
        return $urandom_range(0, 2 * mag) - mag;
    endfunction

    // result side back-pressure
    always @(posedge i_clk) begin
        int g;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            hold_cnt     = 0;
            run_cnt      = 0;
        end else if (hold_cnt > 0) begin
            hold_cnt--;
            res_if.ready <= 1'b0;
        end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_cnt      = HOLD_CYC;
            res_if.ready <= 1'b0;
        end else if (run_cnt > 0) begin
            run_cnt--;
            res_if.ready <= 1'b1;
        end else begin
            g = pick_gap();
            if (g == 0) begin
                run_cnt = $urandom_range(0, 30);
                res_if.ready <= 1'b1;
            end else begin
                hold_cnt = g - 1;
                res_if.ready <= 1'b0;
            end
        end
    end

    task automatic write_reg(logic [pwts_pkg::IDX_W-1:0] idx, logic [63:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(negedge i_clk); while (!cfg_if.ready);
        @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_point(int x, int y, int z);
        int g;
        g = pick_gap();
        if (g > 0) begin
            pt_if.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        pt_if.valid <= 1'b1;
        pt_if.pos_x <= x;
        pt_if.pos_y <= y;
        pt_if.pos_z <= z;
        do @(negedge i_clk); while (!pt_if.ready);
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        pt_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic load_matrix(int m [12], int w, int h);
        write_reg(pwts_pkg::REG_ROW0_AB, {m[1], m[0]});
        write_reg(pwts_pkg::REG_ROW0_CD, {m[3], m[2]});
        write_reg(pwts_pkg::REG_ROW1_AB, {m[5], m[4]});
        write_reg(pwts_pkg::REG_ROW1_CD, {m[7], m[6]});
        write_reg(pwts_pkg::REG_ROW3_AB, {m[9], m[8]});
        write_reg(pwts_pkg::REG_ROW3_CD, {m[11], m[10]});
        write_reg(pwts_pkg::REG_WIDTH, 64'(w));
        write_reg(pwts_pkg::REG_HEIGHT, 64'(h));
    endtask

    initial begin
        int m [12];
        int mode;
        int mag;
        int zmag;
        pt_if.valid   <= 1'b0;
        pt_if.pos_x   <= '0;
        pt_if.pos_y   <= '0;
        pt_if.pos_z   <= '0;
        cfg_if.valid  <= 1'b0;
        cfg_if.index  <= '0;
        cfg_if.data   <= '0;
        long_hold_req = 1'b0;
        i_rst_n       <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero matrix straight out of reset: every point is behind the camera
        send_point(ONE, ONE, ONE);
        wait_drained();

        // identity-like projection, w = z
        m = '{ONE, 0, 0, 0, 0, ONE, 0, 0, 0, 0, ONE, 0};
        load_matrix(m, 1920, 1080);
        write_reg(IDX_UNUSED, '1);
        send_point(0, 0, ONE);
        send_point(ONE, ONE, ONE);
        send_point(-ONE, -ONE, ONE);
        send_point(ONE / 3, -ONE / 7, 3 * ONE);
        send_point(0, 0, 0);
        send_point(0, 0, W_EDGE);
        send_point(0, 0, W_EDGE + 1);
        send_point(0, 0, -ONE);
        send_point(S_MAX, S_MAX, W_EDGE + 1);
        send_point(S_MIN, S_MIN, W_EDGE + 1);
        send_point(S_MAX, S_MIN, S_MAX);
        send_point(S_MIN, S_MAX, S_MIN);
        send_point(S_MAX, S_MAX, S_MAX);
        wait_drained();

        // display too small, then a clip overflow through the offsets
        m = '{S_MAX, S_MAX, S_MAX, S_MAX, S_MIN, S_MIN, S_MIN, S_MIN, 0, 0, ONE, ONE};
        load_matrix(m, 1, 1080);
        send_point(ONE, ONE, ONE);
        send_point(S_MAX, S_MAX, S_MAX);
        wait_drained();
        load_matrix(m, 65535, 0);
        send_point(ONE, ONE, ONE);
        send_point(S_MIN, S_MIN, S_MIN);
        wait_drained();
        load_matrix(m, 65535, 65535);
        send_point(ONE, -ONE, ONE);
        send_point(S_MIN, S_MAX, S_MAX);
        wait_drained();

        for (int ph = 0; ph < 8; ph++) begin
            mode = ph % 4;
            mag  = (mode == 1) ? (64 * ONE) : (4 * ONE);
            zmag = 100 * ONE;
            for (int i = 0; i < 12; i++) begin
                case (mode)
                    2:       m[i] = $urandom;
                    3:       m[i] = ($urandom_range(0, 2) == 0) ? S_MAX :
                                    ($urandom_range(0, 1) ? S_MIN : rand_q(mag));
                    default: m[i] = rand_q(mag);
                endcase
            end
            if (mode < 2) begin
                // keep w mostly tracking z so most points land in front
                m[8]  = rand_q(ONE / 8);
                m[9]  = rand_q(ONE / 8);
                m[10] = ONE + rand_q(ONE / 2);
                m[11] = rand_q(ONE);
            end
            case (ph)
                1:       load_matrix(m, 65535, 65535);
                5:       load_matrix(m, 2, 2);
                default: load_matrix(m, $urandom_range(2, 4096), $urandom_range(2, 4096));
            endcase
            for (int n = 0; n < 160; n++) begin
                if (ph == 2 && n == 20)
                    long_hold_req = 1'b1;
                if ($urandom_range(0, 4) == 0)
                    send_point($urandom, $urandom, $urandom);
                else
                    send_point(rand_q(100 * ONE), rand_q(100 * ONE),
                               $urandom_range(1, zmag) - ONE / 16);
            end
            wait_drained();
        end

        if (fail_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/pwts_pkg.sv
hw/rtl/pwts_if.sv
hw/rtl/pwts_div_cell.sv
hw/rtl/perspective_world_to_screen.sv
tb/pwts_checker.sv
tb/testbench.sv
